// ----- rtl/core/sphkd_pkg.sv -----
// ============================================================================
// sphkd_pkg
// Shared types and constants for the SPH cubic spline density accumulator.
// ============================================================================
package sphkd_pkg;

    // default number of fraction bits of the fixed-point format
    localparam int FRAC_BITS_DEF = 16;

    // width of the density sum and of each term
    localparam int SUM_W = 48;

    // 8/pi scale in Q2.28 and its shift
    localparam int          K_SHIFT = 28;
    localparam logic [29:0] K_Q28   = 30'd683565275;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_CENTER_X  = 2'd0,
        REG_CENTER_Y  = 2'd1,
        REG_CENTER_Z  = 2'd2,
        REG_SMOOTH_LEN = 2'd3
    } cfg_reg_t;

    // one classified neighbour: absolute axis distances, mass, last flag
    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic [31:0] mass;
        logic        last;
    } nbr_entry_t;

    // queue status seen by the back end
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// ----- rtl/core/sph_kernel_density_sum_unit.sv -----
// ============================================================================
// sph_kernel_density_sum_unit
// SPH density accumulator with the 3D cubic spline kernel, signed fixed point.
// ============================================================================
//
//  channel | ports                          | direction | contents
//  --------+--------------------------------+-----------+---------------------------
//  input   | s_tvalid s_tready s_tdata s_tlast | in     | neighbour x,y,z,mass; last
//  result  | m_tvalid m_tready m_tdata m_tuser | out    | density; overflowed flag
//  config  | cfg_valid cfg_ready cfg_index cfg_data | in | centre x,y,z; smoothing h
//
//  A neighbour outside the kernel support goes to the accumulate step without
//  using the square root or the divider; one inside passes through the
//  bit-serial square root and the divider, which is run once for q and
//  three times for the 1/h^3 scaling.
//  A four-entry queue lets the front accept requests while the back end works.
//  Reset is synchronous and active low; it clears the sum, the queue and the
//  configuration to centre 0, h = 1.0. A stalled result holds in its output
//  register, and the back end waits only when a further result is due.
//
module sph_kernel_density_sum_unit #(
    parameter int FRAC_BITS = sphkd_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // neighbor_x[31:0], neighbor_y[63:32],
                                    // neighbor_z[95:64], neighbor_mass[127:96]
    input  logic         s_tlast,   // last_neighbor
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // density[47:0]
    output logic         m_tuser,   // overflowed
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import sphkd_pkg::*;

    q_status_t   q_status;
    nbr_entry_t  push_entry;
    nbr_entry_t  head_entry;
    logic        push;
    logic        pop;
    logic [31:0] smooth_len;

    sphkd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry),
        .smooth_len (smooth_len)
    );

    sphkd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_status   (q_status)
    );

    sphkd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_status   (q_status),
        .head_entry (head_entry),
        .pop        (pop),
        .smooth_len (smooth_len),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

// ----- rtl/core/sphkd_front.sv -----
// ============================================================================
// sphkd_front
// Holds the configuration registers, accepts neighbour requests and turns
// each into absolute per-axis distances for the back end queue.
// ============================================================================
module sphkd_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [127:0]          s_tdata,   // x[31:0], y[63:32], z[95:64], mass[127:96]
    input  logic                  s_tlast,   // last_neighbor
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  sphkd_pkg::q_status_t  q_status,
    output logic                  push,
    output sphkd_pkg::nbr_entry_t push_entry,
    output logic [31:0]           smooth_len
);
    import sphkd_pkg::*;

    logic [31:0] center_x_reg;
    logic [31:0] center_y_reg;
    logic [31:0] center_z_reg;
    logic [31:0] smooth_len_reg;

    // configuration writes, always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            center_z_reg   <= '0;
            smooth_len_reg <= 32'd65536;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CENTER_X:   center_x_reg   <= cfg_data;
                REG_CENTER_Y:   center_y_reg   <= cfg_data;
                REG_CENTER_Z:   center_z_reg   <= cfg_data;
                REG_SMOOTH_LEN: smooth_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign smooth_len = smooth_len_reg;

    // |n - c| fits 32 bits unsigned for any two signed 32-bit values
    function automatic logic [31:0] abs_diff(input logic [31:0] n, input logic [31:0] c);
        logic signed [32:0] d;
        logic signed [32:0] m;
        d = $signed({n[31], n}) - $signed({c[31], c});
        m = -d;
        return d[32] ? m[31:0] : d[31:0];
    endfunction

    // request accepted whenever the queue has room
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && !q_status.full;

    always_comb begin
        push_entry.ax   = abs_diff(s_tdata[31:0],  center_x_reg);
        push_entry.ay   = abs_diff(s_tdata[63:32], center_y_reg);
        push_entry.az   = abs_diff(s_tdata[95:64], center_z_reg);
        push_entry.mass = s_tdata[127:96];
        push_entry.last = s_tlast;
    end

endmodule

// ----- rtl/core/sphkd_fifo.sv -----
// ============================================================================
// sphkd_fifo
// Short queue of classified neighbours between the front and back ends.
// ============================================================================
module sphkd_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  sphkd_pkg::nbr_entry_t push_entry,
    input  logic                  pop,
    output sphkd_pkg::nbr_entry_t head_entry,
    output sphkd_pkg::q_status_t  q_status
);
    import sphkd_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    nbr_entry_t        mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW:0]       count_reg;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == (AW+1)'(DEPTH));
    assign head_entry     = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- rtl/core/sphkd_div.sv -----
// ============================================================================
// sphkd_div
// Restoring divider, one quotient bit per cycle, shared by the q = r/h
// step and the three 1/h scalings.
// ============================================================================
module sphkd_div #(
    parameter int FRAC_BITS = sphkd_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [sphkd_pkg::SUM_W+FRAC_BITS-1:0] dividend,
    input  logic [31:0]                        divisor,
    output logic                               busy,
    output logic                               done,
    output logic [sphkd_pkg::SUM_W+FRAC_BITS-1:0] quotient
);
    import sphkd_pkg::*;

    localparam int DW = SUM_W + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] dvd_reg;
    logic [31:0]   rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [32:0]   rem_sh;
    logic          fits;
    logic [32:0]   rem_sub;

    // one restoring step
    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[DW-1]};
        fits    = (rem_sh >= {1'b0, divisor});
        rem_sub = rem_sh - {1'b0, divisor};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == CW'(DW - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= dividend;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= fits ? rem_sub[31:0] : rem_sh[31:0];
                dvd_reg <= {dvd_reg[DW-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ----- rtl/core/sphkd_back.sv -----
// ============================================================================
// sphkd_back
// Evaluates the cubic spline kernel for one queued neighbour with a shared
// multiplier, an iterative square root and the shared divider, then adds
// the term into the saturating density sum and emits it on the last one.
// ============================================================================
module sphkd_back #(
    parameter int FRAC_BITS = sphkd_pkg::FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sphkd_pkg::q_status_t  q_status,
    input  sphkd_pkg::nbr_entry_t head_entry,
    output logic                  pop,
    input  logic [31:0]           smooth_len,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,   // density[47:0]
    output logic                  m_tuser    // overflowed
);
    import sphkd_pkg::*;

    localparam int DW = SUM_W + FRAC_BITS;
    localparam int XW = FRAC_BITS + 1;
    localparam logic [XW-1:0] ONE  = XW'(1) << FRAC_BITS;
    localparam logic [XW-1:0] HALF = XW'(1) << (FRAC_BITS - 1);
    localparam logic [SUM_W-1:0] MAX_SUM = '1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_SQZ, ST_HH, ST_CMP, ST_SQRT, ST_DIVQ,
        ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_DIVV, ST_ACC
    } state_t;

    state_t          state_reg;
    nbr_entry_t      ent_reg;
    logic [65:0]     prod_reg;
    logic [63:0]     r2_reg;
    logic [63:0]     sq_x_reg;
    logic [32:0]     sq_rem_reg;
    logic [31:0]     root_reg;
    logic [4:0]      it_reg;
    logic [XW-1:0]   x_reg;
    logic            small_reg;
    logic [XW-1:0]   a_reg;
    logic [XW-1:0]   w_reg;
    logic [1:0]      kcnt_reg;
    logic [SUM_W-1:0] term_reg;
    logic            big_reg;
    logic [SUM_W-1:0] sum_reg;
    logic            sat_reg;
    logic            out_valid_reg;
    logic [SUM_W-1:0] out_density_reg;
    logic            out_ovf_reg;
    logic            div_start_reg;
    logic [DW-1:0]   div_dvd_reg;

    logic            div_busy;
    logic            div_done;
    logic [DW-1:0]   div_quot;

    logic [32:0]     mul_a;
    logic [32:0]     mul_b;
    logic [65:0]     mul_p;
    logic [64:0]     r2_sum;
    logic [63:0]     r2_sat;
    logic [34:0]     sq_rem_sh;
    logic [34:0]     sq_trial;
    logic [34:0]     sq_rem_sub;
    logic [XW-1:0]   q_val;
    logic [XW-1:0]   b_val;
    logic signed [XW+4:0] w_poly;
    logic [SUM_W:0]  acc_sum;
    logic            acc_stall;
    logic            emit;
    logic            div_go;

    sphkd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_dvd_reg),
        .divisor  (smooth_len),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQX: begin mul_a = 33'(ent_reg.ax); mul_b = 33'(ent_reg.ax); end
            ST_SQY: begin mul_a = 33'(ent_reg.ay); mul_b = 33'(ent_reg.ay); end
            ST_SQZ: begin mul_a = 33'(ent_reg.az); mul_b = 33'(ent_reg.az); end
            ST_HH:  begin mul_a = 33'(smooth_len); mul_b = 33'(smooth_len); end
            ST_P1:  begin mul_a = 33'(x_reg);      mul_b = 33'(x_reg); end
            ST_P2:  begin mul_a = 33'(prod_reg >> FRAC_BITS); mul_b = 33'(x_reg); end
            ST_P4:  begin mul_a = 33'(w_reg);      mul_b = 33'(ent_reg.mass); end
            ST_P5:  begin mul_a = 33'(prod_reg >> FRAC_BITS); mul_b = 33'(K_Q28); end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    // saturating add of squares
    always_comb begin
        r2_sum = {1'b0, r2_reg} + {1'b0, prod_reg[63:0]};
        r2_sat = r2_sum[64] ? '1 : r2_sum[63:0];
    end

    // square root step: two radicand bits per cycle
    always_comb begin
        sq_rem_sh  = {sq_rem_reg, sq_x_reg[63:62]};
        sq_trial   = {1'b0, root_reg, 2'b01};
        sq_rem_sub = sq_rem_sh - sq_trial;
    end

    // q from the divider, kernel polynomial
    always_comb begin
        q_val  = div_quot[XW-1:0];
        b_val  = XW'(prod_reg >> FRAC_BITS);
        w_poly = $signed({5'd0, ONE}) - $signed((XW+5)'(6) * {5'd0, a_reg})
                 + $signed((XW+5)'(6) * {5'd0, b_val});
    end

    // density accumulate and result slot
    always_comb begin
        acc_sum   = {1'b0, sum_reg} + {1'b0, term_reg};
        acc_stall = ent_reg.last && out_valid_reg && !m_tready;
        emit      = (state_reg == ST_ACC) && ent_reg.last && !acc_stall;
    end

    // divider launch: after the root, after the 8/pi scaling, between scalings
    always_comb begin
        div_go = ((state_reg == ST_SQRT) && (it_reg == 5'd31)) ||
                 (state_reg == ST_P6) ||
                 ((state_reg == ST_DIVV) && div_done && !(|div_quot[DW-1:SUM_W]) &&
                  (kcnt_reg != 2'd2));
    end

    assign pop = (state_reg == ST_IDLE) && !q_status.empty;

    // kernel sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            div_start_reg <= div_go;
            if (emit) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
            prod_reg <= mul_p;
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_status.empty) begin
                        ent_reg   <= head_entry;
                        state_reg <= ST_SQX;
                    end
                end
                ST_SQX: state_reg <= ST_SQY;
                ST_SQY: begin
                    r2_reg    <= prod_reg[63:0];
                    state_reg <= ST_SQZ;
                end
                ST_SQZ: begin
                    r2_reg    <= r2_sat;
                    state_reg <= ST_HH;
                end
                ST_HH: begin
                    r2_reg    <= r2_sat;
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    // outside the kernel support (or h = 0): no contribution
                    if (r2_reg >= prod_reg[63:0]) begin
                        term_reg  <= '0;
                        big_reg   <= 1'b0;
                        state_reg <= ST_ACC;
                    end else begin
                        sq_x_reg   <= r2_reg;
                        sq_rem_reg <= '0;
                        root_reg   <= '0;
                        it_reg     <= '0;
                        state_reg  <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    sq_x_reg <= {sq_x_reg[61:0], 2'b00};
                    if (sq_rem_sh >= sq_trial) begin
                        sq_rem_reg <= sq_rem_sub[32:0];
                        root_reg   <= {root_reg[30:0], 1'b1};
                    end else begin
                        sq_rem_reg <= sq_rem_sh[32:0];
                        root_reg   <= {root_reg[30:0], 1'b0};
                    end
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == 5'd31) begin
                        state_reg <= ST_DIVQ;
                        div_dvd_reg   <= DW'(sq_rem_sh >= sq_trial ?
                                          {root_reg[30:0], 1'b1} : {root_reg[30:0], 1'b0})
                                          << FRAC_BITS;
                    end
                end
                ST_DIVQ: begin
                    if (div_done) begin
                        small_reg <= (q_val <= HALF);
                        x_reg     <= (q_val <= HALF) ? q_val : ONE - q_val;
                        state_reg <= ST_P1;
                    end
                end
                ST_P1: state_reg <= ST_P2;
                ST_P2: begin
                    a_reg     <= XW'(prod_reg >> FRAC_BITS);
                    state_reg <= ST_P3;
                end
                ST_P3: begin
                    if (small_reg) begin
                        w_reg <= w_poly[XW+4] ? '0 : XW'(w_poly);
                    end else begin
                        w_reg <= XW'({b_val, 1'b0});
                    end
                    state_reg <= ST_P4;
                end
                ST_P4: state_reg <= ST_P5;
                ST_P5: state_reg <= ST_P6;
                ST_P6: begin
                    div_dvd_reg   <= DW'(prod_reg >> K_SHIFT) << FRAC_BITS;
                    kcnt_reg      <= '0;
                    state_reg     <= ST_DIVV;
                end
                ST_DIVV: begin
                    if (div_done) begin
                        if (|div_quot[DW-1:SUM_W]) begin
                            term_reg  <= MAX_SUM;
                            big_reg   <= 1'b1;
                            state_reg <= ST_ACC;
                        end else if (kcnt_reg == 2'd2) begin
                            term_reg  <= div_quot[SUM_W-1:0];
                            big_reg   <= 1'b0;
                            state_reg <= ST_ACC;
                        end else begin
                            kcnt_reg      <= kcnt_reg + 1'b1;
                            div_dvd_reg   <= DW'(div_quot[SUM_W-1:0]) << FRAC_BITS;
                        end
                    end
                end
                ST_ACC: begin
                    if (!acc_stall) begin
                        if (ent_reg.last) begin
                            // emit and start a new centre
                            out_density_reg <= (big_reg || acc_sum[SUM_W]) ?
                                               MAX_SUM : acc_sum[SUM_W-1:0];
                            out_ovf_reg     <= big_reg || acc_sum[SUM_W] || sat_reg;
                            sum_reg         <= '0;
                            sat_reg         <= 1'b0;
                        end else if (big_reg || acc_sum[SUM_W]) begin
                            sum_reg <= MAX_SUM;
                            sat_reg <= 1'b1;
                        end else begin
                            sum_reg <= acc_sum[SUM_W-1:0];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_density_reg;
    assign m_tuser  = out_ovf_reg;

    // a result is only raised by the accumulate step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_ACC))
        else $error("result raised outside accumulate");

    // emitting a result clears the running sum
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> (sum_reg == '0 && !sat_reg))
        else $error("sum not cleared after result");

    // the divider is never restarted while running
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start_reg |-> !div_busy)
        else $error("divider restarted while busy");

    // divider idle whenever the sequencer waits for a neighbour
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !div_busy)
        else $error("divider busy in idle");

endmodule

// ----- bench/sphkd_checker.sv -----
// ----------------------------------------------------------------------------
// sphkd_checker
// Watches the neighbour and density channels and the register writes, keeps
// its own kernel density sum and compares every density result with it.
// ----------------------------------------------------------------------------
module sphkd_checker
    import sphkd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [47:0]  m_tdata,
    input  logic         m_tuser,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output int           fail_count,
    output int           pending_count,
    output int           density_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          F     = FRAC_BITS_DEF;
    localparam logic [63:0] MAX48 = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [47:0] density;
        logic        overflowed;
    } density_rec_t;

    density_rec_t density_q[$];

    logic signed [31:0] cen_x, cen_y, cen_z;
    logic [31:0]        h_len;
    logic [63:0]        acc_sum;
    logic               acc_sat;

    assign pending_count = density_q.size();

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic logic [63:0] axis_dist(input logic [31:0] p, input logic [31:0] c);
        logic signed [63:0] d;
        d = 64'(signed'(p)) - 64'(signed'(c));
        return (d < 0) ? 64'(-d) : 64'(d);
    endfunction

    // contribution of one neighbour; big marks a term at or over 2^48
    task automatic kernel_weight_term(input logic [127:0] nb, output logic [63:0] term,
                                      output logic big);
        logic [63:0] ax, ay, az, r2, hh, r, q, v, qq, t, t2, q2, q3, one;
        logic signed [63:0] w;
        one = 64'd1 << F;
        hh  = {32'd0, h_len};
        ax  = axis_dist(nb[31:0], cen_x);
        ay  = axis_dist(nb[63:32], cen_y);
        az  = axis_dist(nb[95:64], cen_z);
        r2  = sat_sum(sat_sum(ax * ax, ay * ay), az * az);
        big  = 1'b0;
        term = 0;
        if (r2 < hh * hh) begin
            r = root64(r2);
            q = (r << F) / hh;
            if (q <= (one >> 1)) begin
                q2 = (q * q) >> F;
                q3 = (q2 * q) >> F;
                w  = signed'(one) - 6 * signed'(q2) + 6 * signed'(q3);
                if (w < 0) w = 0;
            end else begin
                t  = one - q;
                t2 = (t * t) >> F;
                w  = signed'(2 * ((t2 * t) >> F));
            end
            v = (64'(w) * {32'd0, nb[127:96]}) >> F;
            v = (v * 64'(K_Q28)) >> K_SHIFT;
            for (int k = 0; k < 3 && !big; k++) begin
                qq = v / hh;
                if (qq >= (64'd1 << (SUM_W - F))) begin
                    big = 1'b1;
                end else begin
                    v = (qq << F) + (((v % hh) << F) / hh);
                    if (v > MAX48) big = 1'b1;
                end
            end
            term = big ? MAX48 : v;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        logic [63:0]  term;
        logic         big;
        density_rec_t rec;
        if (!aresetn) begin
            cen_x = 0; cen_y = 0; cen_z = 0; h_len = 32'd65536;
            acc_sum = 0; acc_sat = 0;
            density_q.delete();
            fail_count    = 0;
            density_seen <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_CENTER_X:   cen_x = cfg_data;
                    REG_CENTER_Y:   cen_y = cfg_data;
                    REG_CENTER_Z:   cen_z = cfg_data;
                    REG_SMOOTH_LEN: h_len = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                kernel_weight_term(s_tdata, term, big);
                if (big || term > MAX48 - acc_sum) begin
                    acc_sum = MAX48;
                    acc_sat = 1'b1;
                end else begin
                    acc_sum = acc_sum + term;
                end
                if (s_tlast) begin
                    rec.density    = acc_sum[47:0];
                    rec.overflowed = acc_sat;
                    density_q.push_back(rec);
                    acc_sum = 0;
                    acc_sat = 0;
                end
            end
            if (m_tvalid && m_tready) begin
                density_seen <= density_seen + 1;
                if (density_q.size() == 0) begin
                    report_mismatch("unexpected density", {16'd0, m_tdata}, 0);
                end else begin
                    rec = density_q.pop_front();
                    if (m_tdata !== rec.density)
                        report_mismatch("density", {16'd0, m_tdata}, {16'd0, rec.density});
                    if (m_tuser !== rec.overflowed)
                        report_mismatch("overflowed", 64'(m_tuser), 64'(rec.overflowed));
                end
            end
        end
    end
endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus for the SPH density accumulator: directed edge neighbours, then
// random runs around several centres and smoothing lengths with random idling.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sphkd_pkg::*;

    localparam int LIMIT = 3_000_000;

    logic         aclk = 0, aresetn = 0;
    logic         s_tvalid = 0, s_tlast = 0, m_tready = 0, cfg_valid = 0;
    logic [127:0] s_tdata = 0;
    logic [1:0]   cfg_index = 0;
    logic [31:0]  cfg_data = 0;
    logic         s_tready, m_tvalid, m_tuser, cfg_ready;
    logic [47:0]  m_tdata;
    int           fail_count, pending_count, density_seen;
    int           cycles = 0, sent = 0;
    bit           busy_free = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    sph_kernel_density_sum_unit dut (.*);
    sphkd_checker chk (.*);

    // cycle limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side stalls
    always @(negedge aclk) m_tready <= busy_free || ($urandom_range(99) >= 26);

    // called at a falling edge, returns at a falling edge
    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    // waits out every expected density plus the back end's longest pass
    task automatic drain;
        s_tvalid <= 0;
        while (pending_count != 0) @(posedge aclk);
        repeat (5 * 400) @(posedge aclk);
        @(negedge aclk);
    endtask

    // called at a falling edge, returns at a falling edge with the request held
    task automatic send_neighbor(input logic [31:0] x, y, z, m, input logic last);
        while (!busy_free && $urandom_range(99) < 26) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {m, z, y, x};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        @(negedge aclk);
    endtask

    // offset around the centre, scaled so most land inside the support
    function automatic logic [31:0] near(input logic [31:0] c, input logic [31:0] h);
        logic signed [63:0] off;
        off = $signed({1'b0, $urandom_range(32'hFFFF)}) - 32768;
        off = (off * $signed({32'd0, h})) >>> 15;
        return c + off[31:0];
    endfunction

    task automatic random_phase(input logic [31:0] cx, cy, cz, h, input int n);
        int left;
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_SMOOTH_LEN, h);
        left = n;
        while (left > 0) begin
            if ($urandom_range(9) < 8)
                send_neighbor(near(cx, h), near(cy, h), near(cz, h),
                              ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h3FFFF),
                              $urandom_range(3) == 0 || left == 1);
            else
                send_neighbor($urandom, $urandom, $urandom, $urandom, $urandom_range(1));
            left--;
        end
        drain;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk) aresetn <= 1;

        // directed: neighbour at centre, extremes, edge of support, large terms
        send_neighbor(0, 0, 0, 32'h0001_0000, 1);
        send_neighbor(0, 0, 0, 32'hFFFF_FFFF, 1);
        send_neighbor(32'h0000_8000, 0, 0, 32'h0001_0000, 0);
        send_neighbor(0, 32'h0000_C000, 0, 32'h0001_0000, 0);
        send_neighbor(0, 0, 32'h0000_FFFF, 32'h0001_0000, 0);
        send_neighbor(32'h0001_0000, 0, 0, 32'h0001_0000, 1);
        send_neighbor(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1);
        send_neighbor(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1);
        drain;
        write_reg(REG_SMOOTH_LEN, 32'd1);
        send_neighbor(0, 0, 0, 32'hFFFF_FFFF, 1);
        send_neighbor(0, 0, 0, 32'h0000_0001, 0);
        send_neighbor(0, 0, 0, 32'h0000_0001, 1);
        drain;
        write_reg(REG_SMOOTH_LEN, 32'd0);
        send_neighbor(0, 0, 0, 32'hFFFF_FFFF, 1);
        drain;
        write_reg(REG_SMOOTH_LEN, 32'hFFFF_FFFF);
        write_reg(REG_CENTER_X, 32'h8000_0000);
        send_neighbor(32'h8000_0000, 0, 0, 32'hFFFF_FFFF, 0);
        send_neighbor(32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF, 1);
        drain;

        // random phases; one runs without idling on either side
        random_phase(0, 0, 0, 32'h0001_0000, 90);
        random_phase($urandom, $urandom, $urandom, 32'h0000_4000, 90);
        busy_free = 1;
        random_phase(32'h7FFF_0000, 32'h8000_0000, 32'h0, 32'h0010_0000, 90);
        busy_free = 0;
        random_phase($urandom, $urandom, $urandom, $urandom_range(32'h0080_0000, 1), 90);
        random_phase(32'hFFFF_0000, 32'h0001_0000, 32'h1234_5678, 32'd2, 90);

        $display("sent %0d neighbours, %0d densities checked, %0d cycles",
                 sent, density_seen, cycles);
        if (fail_count == 0 && pending_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
